// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the integer to ASCII digit unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check on a given clock, disabled while the active-low reset is low.
`define ITOA_ASSERT_CR(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("itoa check failed");

// Concurrent check on the module's clk_i and rst_ni.
`define ITOA_ASSERT(lbl, prop) \
  `ITOA_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`else

`define ITOA_ASSERT_CR(lbl, clk, rst_n, prop)
`define ITOA_ASSERT(lbl, prop)

`endif

`endif

// ===== rtl/itoa_pkg.sv =====
// Types, constants and helpers shared by the integer to ASCII digit unit.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned DIGIT_W         = 4;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h61 - 8'd10;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  radix;
    logic        signed_mode;
  } itoa_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } itoa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } itoa_div_stat_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {4'b0, d};
    return (d < DIGIT_W'(10)) ? (CH_ZERO + d8) : (CH_ALPHA + d8);
  endfunction

endpackage

// ===== rtl/itoa_div.sv =====
// Iterative divide-by-radix unit: four quotient bits per cycle.
`timescale 1ns / 1ps

module itoa_div
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [((VALUE_WIDTH+DIGIT_W-1)/DIGIT_W)*DIGIT_W-1:0] dividend_i,
  input  logic [4:0]               radix_i,
  output logic [((VALUE_WIDTH+DIGIT_W-1)/DIGIT_W)*DIGIT_W-1:0] quo_o,
  output logic [DIGIT_W-1:0]       rem_o,
  output itoa_div_stat_t           stat_o
);

  localparam int unsigned STEPS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned VP    = STEPS * DIGIT_W;
  localparam int unsigned CNTW  = $clog2(STEPS);

  logic             busy_q, done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [VP-1:0]    quo_q, quo_d;
  logic [4:0]       rad_q;

  // Shift dividend bits out of the top, quotient bits into the bottom.
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [VP-1:0]      sh;
    logic [4:0]         r5;
    logic               qb;
    r  = rem_q;
    sh = quo_q;
    for (int k = 0; k < DIGIT_W; k++) begin
      r5 = {r, sh[VP-1]};
      qb = (r5 >= rad_q);
      if (qb) begin
        r5 = r5 - rad_q;
      end
      sh = {sh[VP-2:0], qb};
      r  = r5[DIGIT_W-1:0];
    end
    rem_d = r;
    quo_d = sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      rad_q <= radix_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o       = quo_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/integer_to_ascii_digits_unit.sv =====
// One character per cycle while the output is taken (a leading '-' goes out early).
// A new request is accepted only when idle, once the last digit of the current one is out.
// Digit time is set by the shared divider, which retires four quotient bits per cycle.
// Reset: asynchronous, active low; clears the sequencer and output valid, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_to_ascii_digits_unit
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itoa_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output itoa_out_t out_data_o
);

  localparam int unsigned STEPS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned VP    = STEPS * DIGIT_W;
  localparam int unsigned DEPTH = VALUE_WIDTH;
  localparam int unsigned NDW   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [4:0]         rad_q, rad_d;
  logic [NDW-1:0]     nd_q, nd_d;
  logic               sign_pend_q, sign_pend_d;
  logic               out_valid_q, out_valid_d;
  itoa_out_t          out_q, out_d;
  logic [DIGIT_W-1:0] stk_q [DEPTH];

  logic [VALUE_WIDTH-1:0] v_in, mag_in;
  logic                   neg_in;
  logic [4:0]             rad_in;
  logic                   out_free;
  logic                   push, pop;

  logic               div_start;
  logic [VP-1:0]      div_dividend, div_quo;
  logic [4:0]         div_radix;
  logic [DIGIT_W-1:0] div_rem;
  itoa_div_stat_t     div_stat;

  assign v_in   = VALUE_WIDTH'(in_data_i.value);
  assign neg_in = in_data_i.signed_mode && v_in[VALUE_WIDTH-1];
  assign mag_in = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;
  assign rad_in = (in_data_i.radix < RADIX_MIN) ? RADIX_MIN :
                  (in_data_i.radix > RADIX_MAX) ? RADIX_MAX : in_data_i.radix;

  assign out_free = !out_valid_q || out_ready_i;

  itoa_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (div_radix),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d      = state_q;
    rad_d        = rad_q;
    nd_d         = nd_q;
    sign_pend_d  = sign_pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    div_start    = 1'b0;
    div_dividend = div_quo;
    div_radix    = rad_q;
    push         = 1'b0;
    pop          = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          div_start    = 1'b1;
          div_dividend = VP'(mag_in);
          div_radix    = rad_in;
          rad_d        = rad_in;
          sign_pend_d  = neg_in;
          nd_d         = '0;
          state_d      = ST_DIV;
        end
      end
      ST_DIV: begin
        // Push each remainder; restart on the quotient until it reaches zero.
        if (div_stat.done) begin
          push = 1'b1;
          nd_d = nd_q + NDW'(1);
          if (div_quo != '0) begin
            div_start = 1'b1;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Hold digits until the minus sign has gone out.
        if (out_free && !sign_pend_q) begin
          pop                 = 1'b1;
          out_valid_d         = 1'b1;
          out_d.char_code     = digit_char(stk_q[0]);
          out_d.last_char     = (nd_q == NDW'(1));
          nd_d                = nd_q - NDW'(1);
          if (nd_q == NDW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sign_pend_q && out_free) begin
      out_valid_d     = 1'b1;
      out_d.char_code = CH_MINUS;
      out_d.last_char = 1'b0;
      sign_pend_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nd_q        <= '0;
      sign_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nd_q        <= nd_d;
      sign_pend_q <= sign_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    out_q <= out_d;
  end

  // Digit stack: the top entry is always the next digit to send.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_q[0] <= div_rem;
      for (int i = 1; i < DEPTH; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ITOA_ASSERT(a_emit_has_digit, (state_q == ST_EMIT) |-> (nd_q != '0))
  `ITOA_ASSERT(a_minus_not_last,
    (out_valid_o && out_data_o.last_char) |-> (out_data_o.char_code != CH_MINUS))
  `ITOA_ASSERT(a_start_when_free, div_start |-> !div_stat.busy)
  `ITOA_ASSERT(a_accept_leaves_idle, (in_valid_i && in_ready_o) |=> !in_ready_o)

endmodule
